>>> rtl/tdfs_pkg.sv
// tdfs_pkg: shared constants, state enum and control structs of the
// timer divider factor search; used by every module in rtl/
package tdfs_pkg;

  // counter width of the timer reload register
  localparam int COUNTER_BITS = 16;
  // prescaler register width and number of prescaler values
  localparam int PSC_BITS = 16;
  localparam int P_W      = PSC_BITS + 1;
  localparam logic [P_W-1:0] PSC_MAX = P_W'(1) << PSC_BITS;

  // field widths
  localparam int TARGET_W = 34;
  localparam int CODE_W   = 2;
  localparam int REG_W    = 16;

  // coarse-divided target and rounded dividend widths
  localparam int D_W   = (COUNTER_BITS + PSC_BITS < TARGET_W) ?
                         COUNTER_BITS + PSC_BITS : TARGET_W;
  localparam int N_W   = D_W + 1;
  localparam int CNT_W = $clog2(N_W + 1);

  // log2 codes of the coarse divide
  localparam logic [CODE_W-1:0] CODE_DIV1 = 2'd0;
  localparam logic [CODE_W-1:0] CODE_DIV2 = 2'd1;
  localparam logic [CODE_W-1:0] CODE_DIV4 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EVAL,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture target, set up scan
    logic init_div;  // start division for current prescaler
    logic step_div;  // one restoring division step
    logic eval;      // compare error, advance prescaler
    logic emit;      // present result item
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic skip;      // zero target or divide too high
    logic div_done;  // quotient and remainder ready
    logic stop;      // zero error or last prescaler
  } stat_t;

endpackage

>>> rtl/timer_divider_factor_search.sv
// timer_divider_factor_search: top level, joins controller and datapath
// depends on tdfs_pkg, tdfs_ctrl, tdfs_dp
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | start & !busy        | target_div
//   result   | done (one cycle)     | clock_div_code, prescale_value,
//            |                      | reload_value, achieved_div, too_high
//
// each prescaler candidate passes through PREP, which forms the rounded
// dividend, DIV, the shared restoring divider (33 steps), and EVAL, which
// compares the error; an item scans up to 65536 candidates, their number
// set by the first prescaler and by how soon a zero error turns up
// zero or out-of-range targets go from PREP straight to OUT
// synchronous reset returns the controller to idle; done strobes once per
// item and cannot be held off by the receiver
module timer_divider_factor_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tdfs_pkg::TARGET_W-1:0] target_div,
  output logic                          done,
  output logic [tdfs_pkg::CODE_W-1:0]   clock_div_code,
  output logic [tdfs_pkg::REG_W-1:0]    prescale_value,
  output logic [tdfs_pkg::REG_W-1:0]    reload_value,
  output logic [tdfs_pkg::TARGET_W-1:0] achieved_div,
  output logic                          too_high
);
  import tdfs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  tdfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // arithmetic and result registers
  tdfs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .target_div     (target_div),
    .stat           (stat),
    .done           (done),
    .clock_div_code (clock_div_code),
    .prescale_value (prescale_value),
    .reload_value   (reload_value),
    .achieved_div   (achieved_div),
    .too_high       (too_high)
  );

endmodule

>>> rtl/tdfs_ctrl.sv
// tdfs_ctrl: sequencing state machine of the factor search
// depends on tdfs_pkg
module tdfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tdfs_pkg::stat_t stat,
  output tdfs_pkg::cmd_t  cmd,
  output logic          busy
);
  import tdfs_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat.skip) begin
          state_next = ST_OUT;
        end else begin
          cmd.init_div = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_EVAL;
        end else begin
          cmd.step_div = 1'b1;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.stop ? ST_OUT : ST_PREP;
      end
      ST_OUT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/tdfs_dp.sv
// tdfs_dp: datapath of the factor search: coarse divide, shared
// restoring divider, best-candidate tracking and result registers
// depends on tdfs_pkg
module tdfs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tdfs_pkg::cmd_t                cmd,
  input  logic [tdfs_pkg::TARGET_W-1:0] target_div,
  output tdfs_pkg::stat_t               stat,
  output logic                          done,
  output logic [tdfs_pkg::CODE_W-1:0]   clock_div_code,
  output logic [tdfs_pkg::REG_W-1:0]    prescale_value,
  output logic [tdfs_pkg::REG_W-1:0]    reload_value,
  output logic [tdfs_pkg::TARGET_W-1:0] achieved_div,
  output logic                          too_high
);
  import tdfs_pkg::*;

  // per-item registers
  logic [CODE_W-1:0] code;
  logic [D_W-1:0]    d;
  logic [P_W-1:0]    p;
  logic              skip_zero;
  logic              skip_high;

  // divider registers
  logic [N_W-1:0]    quo;
  logic [P_W-1:0]    rem;
  logic [CNT_W-1:0]  cnt;

  // best candidate
  logic [P_W-1:0]    best_p;
  logic [P_W-1:0]    best_err;
  logic [N_W-1:0]    best_q;
  logic [N_W-1:0]    best_prod;

  // coarse divide from the input target
  logic [TARGET_W-1:0] coarse_m1;
  logic [CODE_W-1:0]   code_in;
  logic [TARGET_W-1:0] d_full;
  logic [D_W-1:0]      d_in;
  logic [D_W-1:0]      p_pre;
  logic [P_W-1:0]      p_first;

  always_comb begin
    coarse_m1 = target_div >> (COUNTER_BITS + PSC_BITS);
    case (coarse_m1[1:0])
      2'd0:    code_in = CODE_DIV1;
      2'd1:    code_in = CODE_DIV2;
      default: code_in = CODE_DIV4;
    endcase
    d_full = target_div >> code_in;
    d_in   = d_full[D_W-1:0];
    p_pre  = d_in >> COUNTER_BITS;
    if (p_pre >= D_W'(PSC_MAX)) begin
      p_first = PSC_MAX;
    end else begin
      p_first = p_pre[P_W-1:0] + P_W'(1);
    end
  end

  // rounded dividend and restoring step
  logic [P_W-2:0] half;
  logic [N_W-1:0] n_cur;
  logic [P_W:0]   rem_sh;
  logic           fits;

  assign half   = p[P_W-1:1];
  assign n_cur  = {1'b0, d} + N_W'(half);
  assign rem_sh = {rem, quo[N_W-1]};
  assign fits   = rem_sh >= {1'b0, p};

  // error of the current candidate: |half - remainder|
  logic [P_W-1:0] half_ext;
  logic [P_W-1:0] err;
  logic [N_W-1:0] prod;

  assign half_ext = {1'b0, half};
  assign err      = (half_ext >= rem) ? half_ext - rem : rem - half_ext;
  assign prod     = n_cur - N_W'(rem);

  // status
  assign stat.skip     = skip_zero | skip_high;
  assign stat.div_done = (cnt == '0);
  assign stat.stop     = (err == '0) || (p == PSC_MAX);

  // item setup, division and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code      <= code_in;
      d         <= d_in;
      p         <= p_first;
      skip_zero <= (target_div == '0);
      skip_high <= (coarse_m1 > TARGET_W'(3));
      best_err  <= '1;
      best_p    <= p_first;
      best_q    <= '0;
      best_prod <= '0;
    end
    if (cmd.init_div) begin
      quo <= n_cur;
      rem <= '0;
      cnt <= CNT_W'(N_W);
    end
    if (cmd.step_div) begin
      quo <= {quo[N_W-2:0], fits};
      rem <= fits ? rem_sh[P_W-1:0] - p : rem_sh[P_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.eval) begin
      if (err < best_err) begin
        best_err  <= err;
        best_p    <= p;
        best_q    <= quo;
        best_prod <= prod;
      end
      p <= p + P_W'(1);
    end
  end

  // result registers
  logic [P_W-1:0]      psc_m1;
  logic [N_W-1:0]      cnt_m1;
  logic [N_W+1:0]      ach_full;

  assign psc_m1   = best_p - P_W'(1);
  assign cnt_m1   = best_q - N_W'(1);
  assign ach_full = {2'b00, best_prod} << code;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      too_high <= skip_high;
      if (skip_zero || skip_high) begin
        clock_div_code <= '0;
        prescale_value <= '0;
        reload_value   <= '0;
        achieved_div   <= '0;
      end else begin
        clock_div_code <= code;
        prescale_value <= psc_m1[REG_W-1:0];
        reload_value   <= cnt_m1[REG_W-1:0];
        achieved_div   <= ach_full[TARGET_W-1:0];
      end
    end
  end

endmodule
